// ===== rtl/fpt_pkg.sv =====
// Package for the frame pacing timer: field widths, reset values,
// register indexes and request codes.
// No dependencies; imported by frame_pacing_timer.
package fpt_pkg;

    // Tick rate of the timestamp counter.
    localparam int unsigned TICKS_PER_SECOND = 1000000;

    localparam int unsigned TIME_W    = 48;
    localparam int unsigned TARGET_W  = 20;
    localparam int unsigned FACTOR_W  = 5;
    localparam int unsigned LIMIT_W   = TARGET_W + FACTOR_W;
    localparam int unsigned ACC_W     = 32;
    localparam int unsigned COUNT_W   = 16;
    localparam int unsigned ELAPSED_W = 24;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = TARGET_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_PERIOD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTLIER_FACTOR = 2'd2;

    // Configuration reset values.
    localparam logic                RST_FIXED_MODE     = 1'b0;
    localparam logic [TARGET_W-1:0] RST_TARGET_PERIOD  = 20'd16666;
    localparam logic [FACTOR_W-1:0] RST_OUTLIER_FACTOR = 5'd4;

    // Elapsed value shown after reset or restart.
    localparam logic [ELAPSED_W-1:0] ELAPSED_RESTART = ELAPSED_W'(TICKS_PER_SECOND);

    // Request codes carried by the func field.
    localparam logic FUNC_UPDATE  = 1'b0;
    localparam logic FUNC_RESTART = 1'b1;

endpackage

// ===== rtl/frame_pacing_timer.sv =====
// Frame pacing timer: fixed-timestep accumulator with a frames-per-second counter.
// Depends on fpt_pkg for widths, reset values and codes.
// Single module: input register, one update pass, result register.

// The block takes one timestamped item per clock cycle unless the result register
// is held full by a low result_ready, and returns exactly one result for each,
// through the input register and then the result register. Its rate is set by
// the single update pass that reads and writes the timing state (last stamp,
// accumulator, frame counter) once per item. An update item measures the ticks
// since the previous item, replaces an outlier above target_period times
// outlier_factor with target_period, and then either feeds the fixed-step
// accumulator (fixed mode) or reports a frame directly (variable mode). Once a
// second of ticks has passed since the window began, the frame count becomes
// the reported frame rate. A restart item resets the timing state to the given
// timestamp without touching the configuration. Configuration is written through
// cfg_write/cfg_index/cfg_data and must only change while no item is in flight.
module frame_pacing_timer
    import fpt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  item_valid,
    output logic                  item_ready,
    input  logic                  func,
    input  logic [TIME_W-1:0]     now_time,

    output logic                  result_valid,
    input  logic                  result_ready,
    output logic                  update_frame,
    output logic [ELAPSED_W-1:0]  elapsed_ticks,
    output logic [COUNT_W-1:0]    frame_rate
);

    // Configuration, plus the outlier limit product precomputed on each write.
    logic                 fixed_mode_reg;
    logic [TARGET_W-1:0]  target_reg;
    logic [FACTOR_W-1:0]  factor_reg;
    logic [LIMIT_W-1:0]   limit_reg;
    logic [TARGET_W-1:0]  target_next;
    logic [FACTOR_W-1:0]  factor_next;
    logic [LIMIT_W-1:0]   limit_next;

    // Input register.
    logic                 stage_valid_reg;
    logic                 stage_func_reg;
    logic [TIME_W-1:0]    stage_time_reg;

    // Timing state. The frame flag, elapsed and rate registers double as the
    // result register, since they only change when a result is loaded.
    logic                 result_valid_reg;
    logic [TIME_W-1:0]    last_stamp_reg,   last_stamp_next;
    logic [TIME_W-1:0]    window_start_reg, window_start_next;
    logic [ACC_W-1:0]     acc_reg,          acc_next;
    logic [COUNT_W-1:0]   frames_reg,       frames_next;
    logic [COUNT_W-1:0]   rate_reg,         rate_next;
    logic [ELAPSED_W-1:0] elapsed_reg,      elapsed_next;
    logic                 flag_reg,         flag_next;

    // Datapath.
    logic                 advance;
    logic [TIME_W-1:0]    delta_raw;
    logic [TIME_W-1:0]    window_age;
    logic                 is_outlier;
    logic [LIMIT_W-1:0]   delta;
    logic [ACC_W:0]       acc_sum;
    logic [ACC_W-1:0]     acc_sat;
    logic                 fixed_fire;
    logic                 frame_hit;
    logic [COUNT_W-1:0]   frames_inc;
    logic [COUNT_W-1:0]   frames_counted;
    logic                 window_done;

    // The input stage moves on whenever the result register is free or being
    // emptied in the same cycle, so items stream at one per cycle.
    assign advance    = stage_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !stage_valid_reg || advance;

    assign result_valid  = result_valid_reg;
    assign update_frame  = flag_reg;
    assign elapsed_ticks = elapsed_reg;
    assign frame_rate    = rate_reg;

    // Configuration writes; the limit product tracks whichever field changes.
    always_comb
    begin
        target_next = target_reg;
        factor_next = factor_reg;
        unique case (cfg_index)
            REG_TARGET_PERIOD:  target_next = cfg_data[TARGET_W-1:0];
            REG_OUTLIER_FACTOR: factor_next = cfg_data[FACTOR_W-1:0];
            default:            ;
        endcase
        limit_next = LIMIT_W'(target_next) * LIMIT_W'(factor_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fixed_mode_reg <= RST_FIXED_MODE;
            target_reg     <= RST_TARGET_PERIOD;
            factor_reg     <= RST_OUTLIER_FACTOR;
            limit_reg      <= LIMIT_W'(RST_TARGET_PERIOD) * LIMIT_W'(RST_OUTLIER_FACTOR);
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_FIXED_MODE)
            begin
                fixed_mode_reg <= cfg_data[0];
            end
            target_reg <= target_next;
            factor_reg <= factor_next;
            limit_reg  <= limit_next;
        end
    end

    // Delta since the previous item, modulo 2^48. Anything with bits above the
    // limit width is an outlier by construction, which also covers time that
    // runs backwards.
    assign delta_raw  = stage_time_reg - last_stamp_reg;
    assign window_age = stage_time_reg - window_start_reg;
    assign is_outlier = (|delta_raw[TIME_W-1:LIMIT_W]) || (delta_raw[LIMIT_W-1:0] > limit_reg);
    assign delta      = is_outlier ? LIMIT_W'(target_reg) : delta_raw[LIMIT_W-1:0];

    // Saturating accumulate for fixed-step pacing.
    assign acc_sum    = {1'b0, acc_reg} + (ACC_W + 1)'(delta);
    assign acc_sat    = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
    assign fixed_fire = acc_sat >= ACC_W'(target_reg);

    assign frame_hit      = fixed_mode_reg ? fixed_fire : 1'b1;
    assign frames_inc     = (&frames_reg) ? frames_reg : frames_reg + 1'b1;
    assign frames_counted = frame_hit ? frames_inc : frames_reg;
    assign window_done    = window_age >= TIME_W'(TICKS_PER_SECOND);

    always_comb
    begin
        last_stamp_next   = stage_time_reg;
        window_start_next = window_start_reg;
        acc_next          = acc_reg;
        frames_next       = frames_counted;
        rate_next         = rate_reg;
        elapsed_next      = elapsed_reg;
        flag_next         = frame_hit;

        if (stage_func_reg == FUNC_RESTART)
        begin
            window_start_next = stage_time_reg;
            acc_next          = '0;
            frames_next       = '0;
            rate_next         = '0;
            elapsed_next      = ELAPSED_RESTART;
            flag_next         = 1'b0;
        end
        else
        begin
            if (fixed_mode_reg)
            begin
                // A fired frame is credited exactly one target period.
                acc_next = fixed_fire ? acc_sat - ACC_W'(target_reg) : acc_sat;
                if (fixed_fire)
                begin
                    elapsed_next = ELAPSED_W'(target_reg);
                end
            end
            else
            begin
                elapsed_next = (|delta[LIMIT_W-1:ELAPSED_W]) ? {ELAPSED_W{1'b1}}
                                                             : delta[ELAPSED_W-1:0];
            end

            if (window_done)
            begin
                rate_next         = frames_counted;
                frames_next       = '0;
                window_start_next = stage_time_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            stage_func_reg <= func;
            stage_time_reg <= now_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
            last_stamp_reg   <= '0;
            window_start_reg <= '0;
            acc_reg          <= '0;
            frames_reg       <= '0;
            rate_reg         <= '0;
            elapsed_reg      <= ELAPSED_RESTART;
            flag_reg         <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                stage_valid_reg <= item_valid;
            end

            if (advance)
            begin
                result_valid_reg <= 1'b1;
                last_stamp_reg   <= last_stamp_next;
                window_start_reg <= window_start_next;
                acc_reg          <= acc_next;
                frames_reg       <= frames_next;
                rate_reg         <= rate_next;
                elapsed_reg      <= elapsed_next;
                flag_reg         <= flag_next;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // A restart clears the accumulator, frame count, rate and frame flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && stage_func_reg == FUNC_RESTART |=>
            acc_reg == '0 && frames_reg == '0 && rate_reg == '0 && !update_frame)
        else $error("restart did not clear pacing state");

    // In variable mode every update produces a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && stage_func_reg == FUNC_UPDATE && !fixed_mode_reg |=> update_frame)
        else $error("variable-mode update without a frame");

    // In fixed mode a fired frame is credited exactly one target period.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && stage_func_reg == FUNC_UPDATE && fixed_mode_reg |=>
            !update_frame || elapsed_ticks == ELAPSED_W'($past(target_reg)))
        else $error("fixed-mode frame credited wrong elapsed ticks");

    // An empty input stage must always be able to take an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !stage_valid_reg |-> item_ready)
        else $error("input stage empty but not ready");

endmodule
